>>> rtl/eka_pkg.sv
// ----------------------------------------------------------------------------
// eka_pkg
// Shared constants, coefficient tables and pipeline record types for the
// K/E elliptic integral pipeline.
// ----------------------------------------------------------------------------
package eka_pkg;

    localparam int RESULT_FRAC_BITS = 28;
    localparam int POLY_DEGREE      = 10;
    localparam int WFRAC            = 56;
    localparam int OUT_SHIFT        = WFRAC - RESULT_FRAC_BITS;
    localparam int LOG_BITS         = 32;

    typedef logic [63:0] t_q56;

    // decimal coefficient times 10^18 to unsigned Q.56, rounded to nearest
    function automatic t_q56 dec_to_q56(input logic [63:0] v);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        num = {64'd0, v} << WFRAC;
        q   = num / 128'd1000000000000000000;
        r   = num % 128'd1000000000000000000;
        if ((r << 1) >= 128'd1000000000000000000) begin
            q = q + 128'd1;
        end
        return q[63:0];
    endfunction

    typedef logic [63:0] t_coef_row [0:POLY_DEGREE];

    localparam t_coef_row PK_DEC = '{
        64'd1386294361119890625, 64'd96573590281169013, 64'd30885146524671200,
        64'd14938044891680525, 64'd8790782739527438, 64'd6189010336376876,
        64'd6874896874499499, 64'd9858213790212260, 64'd7974040132204152,
        64'd2280257240058756, 64'd137982864606273};
    localparam t_coef_row QK_DEC = '{
        64'd500000000000000000, 64'd124999999999870820, 64'd70312499696395747,
        64'd48828034757099824, 64'd37377431417382323, 64'd30120471522760405,
        64'd23908960271592489, 64'd15485051664976240, 64'd5940583037531678,
        64'd914184723865917, 64'd29407895504860};
    localparam t_coef_row PE_DEC = '{
        64'd1000000000000000003, 64'd443147180560990851, 64'd56805194561786055,
        64'd21831799601555725, 64'd11568843681057413, 64'd7583952894135147,
        64'd7773954925167871, 64'd10735094905607619, 64'd8687868165658896,
        64'd2508884921636021, 64'd153552577301013};
    localparam t_coef_row QE_DEC = '{
        64'd0, 64'd249999999999888314, 64'd93749999719764428,
        64'd58593663447110106, 64'd42718092651893151, 64'd33483390488822492,
        64'd26176974245449366, 64'd16886216399331132, 64'd6506094899769275,
        64'd1009627926793567, 64'd32795489857649};

    localparam logic [63:0] LN2_DEC = 64'd693147180559945309;

    // coefficient by polynomial (0 Pk, 1 Qk, 2 Pe, 3 Qe) and power of m1
    function automatic t_q56 coef(input logic [1:0] row, input logic [3:0] k);
        logic [63:0] d;
        case (row)
            2'd0:    d = PK_DEC[k];
            2'd1:    d = QK_DEC[k];
            2'd2:    d = PE_DEC[k];
            default: d = QE_DEC[k];
        endcase
        return dec_to_q56(d);
    endfunction

    // low half of a Horner product: round(a_lo*b / 2^32), b up to 2^32
    // (a_lo*b + 2^31 stays below 2^64)
    function automatic logic [31:0] mul_lo_rnd(input logic [31:0] a, input logic [32:0] b);
        logic [64:0] p;
        p = {33'd0, a} * {32'd0, b} + 65'h80000000;
        return p[63:32];
    endfunction

    // high half of a Horner product plus the rounded low half and coefficient
    function automatic t_q56 mul_hi_add(input logic [31:0] a, input logic [32:0] b,
                                        input logic [31:0] lo, input t_q56 c);
        logic [64:0] p;
        p = {33'd0, a} * {32'd0, b} + {33'd0, lo} + {1'b0, c};
        return p[63:0];
    endfunction

    typedef struct packed {
        logic        vld;
        logic [32:0] m1;
        t_q56        pk;
        t_q56        qk;
        t_q56        pe;
        t_q56        qe;
    } t_poly_stage;

    typedef struct packed {
        logic        vld;
        logic [32:0] m1;
        logic [31:0] pk_hi;
        logic [31:0] qk_hi;
        logic [31:0] pe_hi;
        logic [31:0] qe_hi;
        logic [31:0] pk_lo;
        logic [31:0] qk_lo;
        logic [31:0] pe_lo;
        logic [31:0] qe_lo;
    } t_horner_mid;

    typedef struct packed {
        logic        vld;
        logic [31:0] z;
        logic [5:0]  s1;
        logic [31:0] f;
        logic        m1_zero;
        logic        m1_one;
    } t_log_stage;

endpackage

>>> rtl/elliptic_ke_approximation.sv
// ----------------------------------------------------------------------------
// elliptic_ke_approximation
// Complete elliptic integrals K(m) and E(m) by polynomial-log approximation.
// ----------------------------------------------------------------------------
// One m per cycle may be started (busy is always low); each result appears
// with o_done high for one cycle at the end of this chain of registers:
// the m1 register and a normalize stage feed a 32-stage log-by-squaring chain,
// while the 10 Horner steps (two stages each) run beside it; then two stages
// form -ln(m1), one takes partial products, one sums K and E, and an output
// rounding stage follows. The receiver cannot stall; results must be taken
// when o_done is high. m above 1.0 is treated as 1.0, which gives K saturated
// and E equal to Pe(0).
module elliptic_ke_approximation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [32:0] i_m_param,
    output logic        o_done,
    output logic [31:0] o_k_value,
    output logic        o_k_saturated,
    output logic [31:0] o_e_value,
    output logic [31:0] o_k_poly_p,
    output logic [31:0] o_k_poly_q,
    output logic [31:0] o_e_poly_p,
    output logic [31:0] o_e_poly_q
);
    localparam int ND = eka_pkg::POLY_DEGREE;
    localparam int NL = eka_pkg::LOG_BITS;
    // log chain: 1 normalize + 32 squaring stages; polys: 2*ND stages, then delay
    localparam int NP = NL + 1;

    assign busy = 1'b0;

    // ---------------- stage 0: clamp, m1 ----------------
    eka_pkg::t_poly_stage r_p [0:ND];
    eka_pkg::t_horner_mid r_h [1:ND];
    logic [32:0] n_m1;
    always_comb begin
        if (i_m_param > 33'h100000000) begin
            n_m1 = 33'd0;
        end else begin
            n_m1 = 33'h100000000 - i_m_param;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p[0].vld <= 1'b0;
        end else begin
            r_p[0].vld <= start;
        end
        r_p[0].m1 <= n_m1;
        r_p[0].pk <= eka_pkg::coef(2'd0, 4'(ND));
        r_p[0].qk <= eka_pkg::coef(2'd1, 4'(ND));
        r_p[0].pe <= eka_pkg::coef(2'd2, 4'(ND));
        r_p[0].qe <= eka_pkg::coef(2'd3, 4'(ND));
    end

    // ---------------- Horner stages ----------------
    // each step: low 32 bits of acc times m1 first, then high half plus coefficient
    for (genvar g = 1; g <= ND; g++) begin : g_horner
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_h[g].vld <= 1'b0;
                r_p[g].vld <= 1'b0;
            end else begin
                r_h[g].vld <= r_p[g-1].vld;
                r_p[g].vld <= r_h[g].vld;
            end
            r_h[g].m1    <= r_p[g-1].m1;
            r_h[g].pk_hi <= r_p[g-1].pk[63:32];
            r_h[g].qk_hi <= r_p[g-1].qk[63:32];
            r_h[g].pe_hi <= r_p[g-1].pe[63:32];
            r_h[g].qe_hi <= r_p[g-1].qe[63:32];
            r_h[g].pk_lo <= eka_pkg::mul_lo_rnd(r_p[g-1].pk[31:0], r_p[g-1].m1);
            r_h[g].qk_lo <= eka_pkg::mul_lo_rnd(r_p[g-1].qk[31:0], r_p[g-1].m1);
            r_h[g].pe_lo <= eka_pkg::mul_lo_rnd(r_p[g-1].pe[31:0], r_p[g-1].m1);
            r_h[g].qe_lo <= eka_pkg::mul_lo_rnd(r_p[g-1].qe[31:0], r_p[g-1].m1);
            r_p[g].m1 <= r_h[g].m1;
            r_p[g].pk <= eka_pkg::mul_hi_add(r_h[g].pk_hi, r_h[g].m1, r_h[g].pk_lo,
                                             eka_pkg::coef(2'd0, 4'(ND - g)));
            r_p[g].qk <= eka_pkg::mul_hi_add(r_h[g].qk_hi, r_h[g].m1, r_h[g].qk_lo,
                                             eka_pkg::coef(2'd1, 4'(ND - g)));
            r_p[g].pe <= eka_pkg::mul_hi_add(r_h[g].pe_hi, r_h[g].m1, r_h[g].pe_lo,
                                             eka_pkg::coef(2'd2, 4'(ND - g)));
            r_p[g].qe <= eka_pkg::mul_hi_add(r_h[g].qe_hi, r_h[g].m1, r_h[g].qe_lo,
                                             eka_pkg::coef(2'd3, 4'(ND - g)));
        end
    end

    // align polynomials with the log chain
    localparam int NDLY = NP - 2 * ND;
    eka_pkg::t_poly_stage r_d [0:NDLY-1];
    for (genvar g = 0; g < NDLY; g++) begin : g_pdly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[g].vld <= 1'b0;
            end else begin
                r_d[g].vld <= (g == 0) ? r_p[ND].vld : r_d[(g == 0) ? 0 : g-1].vld;
            end
            if (g == 0) begin
                r_d[g].m1 <= r_p[ND].m1;
                r_d[g].pk <= r_p[ND].pk;
                r_d[g].qk <= r_p[ND].qk;
                r_d[g].pe <= r_p[ND].pe;
                r_d[g].qe <= r_p[ND].qe;
            end else begin
                r_d[g].m1 <= r_d[(g == 0) ? 0 : g-1].m1;
                r_d[g].pk <= r_d[(g == 0) ? 0 : g-1].pk;
                r_d[g].qk <= r_d[(g == 0) ? 0 : g-1].qk;
                r_d[g].pe <= r_d[(g == 0) ? 0 : g-1].pe;
                r_d[g].qe <= r_d[(g == 0) ? 0 : g-1].qe;
            end
        end
    end

    // ---------------- log: normalize (leading-zero count) ----------------
    eka_pkg::t_log_stage r_l [0:NL];
    logic [31:0] n_z;
    logic [5:0]  n_s;
    always_comb begin
        n_z = r_p[0].m1[31:0];
        n_s = 6'd0;
        for (int b = 31; b >= 0; b--) begin
            if (r_p[0].m1[b] && n_s == 6'd0 && n_z == r_p[0].m1[31:0]) begin
                n_z = r_p[0].m1[31:0] << (31 - b);
                n_s = 6'(31 - b) | 6'd32;
            end
        end
        n_s = n_s & 6'd31;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l[0].vld <= 1'b0;
        end else begin
            r_l[0].vld <= r_p[0].vld;
        end
        r_l[0].z       <= n_z;
        r_l[0].s1      <= n_s + 6'd1;
        r_l[0].f       <= 32'd0;
        r_l[0].m1_zero <= (r_p[0].m1 == 33'd0);
        r_l[0].m1_one  <= r_p[0].m1[32];
    end

    for (genvar g = 1; g <= NL; g++) begin : g_log
        logic [63:0] sq;
        assign sq = ({32'd0, r_l[g-1].z} * {32'd0, r_l[g-1].z} + 64'h40000000) >> 31;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_l[g].vld <= 1'b0;
            end else begin
                r_l[g].vld <= r_l[g-1].vld;
            end
            r_l[g].s1      <= r_l[g-1].s1;
            r_l[g].m1_zero <= r_l[g-1].m1_zero;
            r_l[g].m1_one  <= r_l[g-1].m1_one;
            if (sq[32]) begin
                r_l[g].z <= sq[32:1];
                r_l[g].f <= {r_l[g-1].f[30:0], 1'b1};
            end else begin
                r_l[g].z <= sq[31:0];
                r_l[g].f <= {r_l[g-1].f[30:0], 1'b0};
            end
        end
    end

    // ---------------- L = t * ln2, split on the 32-bit halves of ln2 ----------------
    localparam eka_pkg::t_q56 LN2_Q56 = eka_pkg::dec_to_q56(eka_pkg::LN2_DEC);
    eka_pkg::t_poly_stage r_a;
    logic        r_a_zero;
    logic        r_a_nolog;
    logic [38:0] r_lp_lo;
    logic [69:0] r_lp_hi;
    logic [37:0] lt_val;
    logic [70:0] lp_lo;
    logic [69:0] lp_hi;
    assign lt_val = {r_l[NL].s1, 32'd0} - {6'd0, r_l[NL].f};
    assign lp_lo  = {33'd0, lt_val} * {39'd0, LN2_Q56[31:0]} + 71'h80000000;
    assign lp_hi  = {32'd0, lt_val} * {38'd0, LN2_Q56[63:32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
        end else begin
            r_a.vld <= r_d[NDLY-1].vld;
        end
        r_a.m1    <= r_d[NDLY-1].m1;
        r_a.pk    <= r_d[NDLY-1].pk;
        r_a.qk    <= r_d[NDLY-1].qk;
        r_a.pe    <= r_d[NDLY-1].pe;
        r_a.qe    <= r_d[NDLY-1].qe;
        r_a_zero  <= r_l[NL].m1_zero;
        r_a_nolog <= r_l[NL].m1_one || r_l[NL].m1_zero;
        r_lp_lo   <= lp_lo[70:32];
        r_lp_hi   <= lp_hi;
    end

    eka_pkg::t_poly_stage r_b;
    logic          r_b_zero;
    eka_pkg::t_q56 r_lnv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.vld <= 1'b0;
        end else begin
            r_b.vld <= r_a.vld;
        end
        r_b.m1   <= r_a.m1;
        r_b.pk   <= r_a.pk;
        r_b.qk   <= r_a.qk;
        r_b.pe   <= r_a.pe;
        r_b.qe   <= r_a.qe;
        r_b_zero <= r_a_zero;
        r_lnv    <= r_a_nolog ? 64'd0 : (r_lp_hi[63:0] + {25'd0, r_lp_lo});
    end

    // ---------------- K56, E56: 32x32 partial products, then one sum ----------------
    function automatic logic [3:0][63:0] part4(input eka_pkg::t_q56 a,
                                               input eka_pkg::t_q56 b);
        logic [3:0][63:0] p;
        p[0] = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
        p[1] = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
        p[2] = {32'd0, a[63:32]} * {32'd0, b[31:0]};
        p[3] = {32'd0, a[63:32]} * {32'd0, b[63:32]};
        return p;
    endfunction

    // c + round(a*b / 2^56) from the partial products of a*b
    function automatic eka_pkg::t_q56 sum_scaled(input logic [3:0][63:0] p,
                                                 input eka_pkg::t_q56 c);
        logic [127:0] s;
        s = {p[3], 64'd0} + {32'd0, p[2], 32'd0} + {32'd0, p[1], 32'd0}
            + {64'd0, p[0]} + (128'd1 << (eka_pkg::WFRAC - 1))
            + ({64'd0, c} << eka_pkg::WFRAC);
        return s[eka_pkg::WFRAC +: 64];
    endfunction

    eka_pkg::t_poly_stage r_c;
    logic             r_c_zero;
    logic [3:0][63:0] r_kpp;
    logic [3:0][63:0] r_epp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else begin
            r_c.vld <= r_b.vld;
        end
        r_c.m1   <= r_b.m1;
        r_c.pk   <= r_b.pk;
        r_c.qk   <= r_b.qk;
        r_c.pe   <= r_b.pe;
        r_c.qe   <= r_b.qe;
        r_c_zero <= r_b_zero;
        r_kpp    <= part4(r_b.qk, r_lnv);
        r_epp    <= part4(r_b.qe, r_lnv);
    end

    eka_pkg::t_poly_stage r_s;
    logic          r_s_zero;
    eka_pkg::t_q56 r_k56;
    eka_pkg::t_q56 r_e56;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.vld <= 1'b0;
        end else begin
            r_s.vld <= r_c.vld;
        end
        r_s.m1   <= r_c.m1;
        r_s.pk   <= r_c.pk;
        r_s.qk   <= r_c.qk;
        r_s.pe   <= r_c.pe;
        r_s.qe   <= r_c.qe;
        r_s_zero <= r_c_zero;
        r_k56    <= sum_scaled(r_kpp, r_c.pk);
        r_e56    <= sum_scaled(r_epp, r_c.pe);
    end

    // ---------------- output rounding ----------------
    function automatic logic [32:0] to_out(input eka_pkg::t_q56 v);
        logic [64:0] r;
        r = ({1'b0, v} + (65'd1 << (eka_pkg::OUT_SHIFT - 1))) >> eka_pkg::OUT_SHIFT;
        if (r > 65'hFFFFFFFF) begin
            return {1'b1, 32'hFFFFFFFF};
        end
        return {1'b0, r[31:0]};
    endfunction

    logic [32:0] k_o;
    logic [32:0] e_o;
    logic [32:0] pk_o;
    logic [32:0] qk_o;
    logic [32:0] pe_o;
    logic [32:0] qe_o;
    assign k_o  = to_out(r_k56);
    assign e_o  = to_out(r_e56);
    assign pk_o = to_out(r_s.pk);
    assign qk_o = to_out(r_s.qk);
    assign pe_o = to_out(r_s.pe);
    assign qe_o = to_out(r_s.qe);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_s.vld;
        end
        if (r_s_zero) begin
            o_k_value     <= 32'hFFFFFFFF;
            o_k_saturated <= 1'b1;
        end else begin
            o_k_value     <= k_o[31:0];
            o_k_saturated <= k_o[32];
        end
        o_e_value  <= r_s_zero ? pe_o[31:0] : e_o[31:0];
        o_k_poly_p <= pk_o[31:0];
        o_k_poly_q <= qk_o[31:0];
        o_e_poly_p <= pe_o[31:0];
        o_e_poly_q <= qe_o[31:0];
    end

    // ---------------- assertions ----------------
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d[NDLY-1].vld == r_l[NL].vld)
        else $error("poly and log pipelines misaligned");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a.vld |-> ##4 o_done)
        else $error("result lost in output stages");
    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s.vld && r_s_zero) |=> (o_k_saturated && o_k_value == 32'hFFFFFFFF))
        else $error("m equal to one not saturated");
    a_m1_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_l[NL].vld && r_l[NL].m1_one) |-> ##2 (r_lnv == 64'd0))
        else $error("log nonzero at m equal to zero");
endmodule

>>> dv/tb_elliptic_ke_approximation.sv
// ----------------------------------------------------------------------------
// tb_elliptic_ke_approximation
// Self-checking testbench for the K/E elliptic integral pipeline: drives m
// values with random start gaps, predicts every result field in fixed point
// and checks each o_done transaction in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_elliptic_ke_approximation;

    localparam logic [32:0] M_ONE = 33'h1_0000_0000;
    localparam int          DRAIN = 60;

    typedef struct packed {
        logic [31:0] k_value;
        logic        k_saturated;
        logic [31:0] e_value;
        logic [31:0] k_poly_p;
        logic [31:0] k_poly_q;
        logic [31:0] e_poly_p;
        logic [31:0] e_poly_q;
    } t_ke_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [32:0] i_m_param;
    logic        o_done;
    logic [31:0] o_k_value;
    logic        o_k_saturated;
    logic [31:0] o_e_value;
    logic [31:0] o_k_poly_p;
    logic [31:0] o_k_poly_q;
    logic [31:0] o_e_poly_p;
    logic [31:0] o_e_poly_q;

    t_ke_result ke_pending[$];
    int         err_count = 0;

    elliptic_ke_approximation uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_m_param(i_m_param),
        .o_done(o_done),
        .o_k_value(o_k_value),
        .o_k_saturated(o_k_saturated),
        .o_e_value(o_e_value),
        .o_k_poly_p(o_k_poly_p),
        .o_k_poly_q(o_k_poly_q),
        .o_e_poly_p(o_e_poly_p),
        .o_e_poly_q(o_e_poly_q)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // decimal times 10^18 to Q.56, round to nearest, ties up
    function automatic logic [63:0] dec_q56(input logic [63:0] d);
        logic [127:0] n;
        n = ({64'd0, d} << eka_pkg::WFRAC) + 128'd500000000000000000;
        n = n / 128'd1000000000000000000;
        return n[63:0];
    endfunction

    function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        return p[63:0];
    endfunction

    function automatic logic [63:0] horner_at(input eka_pkg::t_coef_row c,
                                              input logic [63:0] m1);
        logic [63:0] acc;
        acc = dec_q56(c[eka_pkg::POLY_DEGREE]);
        for (int k = eka_pkg::POLY_DEGREE - 1; k >= 0; k--) begin
            acc = mul_round(acc, m1, 32) + dec_q56(c[k]);
        end
        return acc;
    endfunction

    // -ln(v / 2^32) in Q.56, 1 <= v < 2^32
    function automatic logic [63:0] minus_ln(input logic [63:0] v);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] f;
        logic [63:0] t;
        int          s;
        z = v;
        f = 0;
        s = 0;
        while (z < 64'h8000_0000) begin
            z = z << 1;
            s++;
        end
        for (int i = 0; i < 32; i++) begin
            z2 = (z * z + 64'h4000_0000) >> 31;
            f = f << 1;
            if (z2 >= 64'h1_0000_0000) begin
                f[0] = 1'b1;
                z = z2 >> 1;
            end else begin
                z = z2;
            end
        end
        t = (64'(s + 1) << 32) - f;
        return mul_round(t, dec_q56(eka_pkg::LN2_DEC), 32);
    endfunction

    function automatic logic [31:0] round_out(input logic [63:0] v, output logic sat);
        logic [64:0] r;
        r = ({1'b0, v} + (65'd1 << (eka_pkg::OUT_SHIFT - 1))) >> eka_pkg::OUT_SHIFT;
        sat = (r > 65'hFFFF_FFFF);
        return sat ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic t_ke_result ke_predict(input logic [32:0] m_in);
        t_ke_result  r;
        logic [63:0] m;
        logic [63:0] m1;
        logic [63:0] pk;
        logic [63:0] qk;
        logic [63:0] pe;
        logic [63:0] qe;
        logic [63:0] lnv;
        logic        ks;
        logic        dummy;
        m = {31'd0, m_in};
        if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
        m1 = 64'h1_0000_0000 - m;
        pk = horner_at(eka_pkg::PK_DEC, m1);
        qk = horner_at(eka_pkg::QK_DEC, m1);
        pe = horner_at(eka_pkg::PE_DEC, m1);
        qe = horner_at(eka_pkg::QE_DEC, m1);
        if (m1 == 0) begin
            r.k_value = 32'hFFFF_FFFF;
            ks = 1'b1;
            r.e_value = round_out(pe, dummy);
        end else begin
            lnv = (m1 == 64'h1_0000_0000) ? 64'd0 : minus_ln(m1);
            r.k_value = round_out(pk + mul_round(qk, lnv, eka_pkg::WFRAC), ks);
            r.e_value = round_out(pe + mul_round(qe, lnv, eka_pkg::WFRAC), dummy);
        end
        r.k_saturated = ks;
        r.k_poly_p = round_out(pk, dummy);
        r.k_poly_q = round_out(qk, dummy);
        r.e_poly_p = round_out(pe, dummy);
        r.e_poly_q = round_out(qe, dummy);
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 60);
    endfunction

    task automatic send_m(input logic [32:0] m);
        int g;
        start <= 1'b1;
        i_m_param <= m;
        do @(posedge i_clk); while (busy);
        ke_pending.push_back(ke_predict(m));
        g = gap_len();
        if (g > 0) begin
            start <= 1'b0;
            i_m_param <= 33'({$urandom, $urandom});
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (ke_pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic chk(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // result checker: one transaction per o_done cycle
    always @(posedge i_clk) begin
        t_ke_result e;
        if (i_rst_n && o_done === 1'b1) begin
            if (ke_pending.size() == 0) begin
                $display("%0t: unexpected result, expected none actual k=%h", $time, o_k_value);
                err_count++;
            end else begin
                e = ke_pending.pop_front();
                chk("k_value", e.k_value, o_k_value);
                chk("k_saturated", {31'd0, e.k_saturated}, {31'd0, o_k_saturated});
                chk("e_value", e.e_value, o_e_value);
                chk("k_poly_p", e.k_poly_p, o_k_poly_p);
                chk("k_poly_q", e.k_poly_q, o_k_poly_q);
                chk("e_poly_p", e.e_poly_p, o_e_poly_p);
                chk("e_poly_q", e.e_poly_q, o_e_poly_q);
            end
        end
    end

    task automatic test_directed();
        logic [32:0] pts[$];
        pts = {33'd0, M_ONE, M_ONE + 33'd1, 33'h1_FFFF_FFFF, 33'd1, M_ONE - 33'd1,
               M_ONE - 33'd2, 33'h0_8000_0000, 33'h0_4000_0000, 33'h0_C000_0000,
               33'h0_FFFF_0000, 33'h0_5555_5555, 33'h0_AAAA_AAAA, 33'h1_8000_0000,
               33'h0_0000_FFFF, M_ONE - 33'h100, M_ONE - 33'h8000_0001};
        foreach (pts[i]) send_m(pts[i]);
    endtask

    task automatic test_uniform(input int n);
        repeat (n) send_m({1'b0, $urandom});
    endtask

    // m close to one: small m1 drives the log normalization deep
    task automatic test_near_one(input int n);
        int b;
        repeat (n) begin
            b = $urandom_range(0, 31);
            send_m(M_ONE - 33'($urandom_range(1, 32'hFFFF_FFFF >> b)));
        end
    endtask

    task automatic test_out_of_range(input int n);
        repeat (n) send_m({1'b1, $urandom});
    endtask

    task automatic test_burst(input int n);
        start <= 1'b1;
        repeat (n) begin
            i_m_param <= {1'b0, $urandom};
            do @(posedge i_clk); while (busy);
            ke_pending.push_back(ke_predict(i_m_param));
        end
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int spin;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_m_param = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_uniform(600);
        test_near_one(450);
        wait_drained();
        test_burst(200);
        test_out_of_range(80);
        test_uniform(100);

        start <= 1'b0;
        spin = 0;
        while (ke_pending.size() != 0 && spin < 10000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (DRAIN) @(posedge i_clk);
        if (err_count == 0 && ke_pending.size() == 0) begin
            $display("PASS elliptic_ke_approximation");
        end else begin
            $display("FAIL elliptic_ke_approximation");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL elliptic_ke_approximation");
        $finish;
    end

endmodule
